/* rtl/core/phd_pkg.sv */
// shared types and constants for the pre-order huffman tree decoder
package phd_pkg;

  parameter int PHD_COUNT_BITS = 24;

  localparam int NODE_W      = 9;
  localparam int SLOT_W      = 10;
  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int CFG_INDEX_W = 1;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [TABLE_AW-1:0] taddr_t;

  localparam slot_t ROOT_SLOT     = 10'd512;
  localparam slot_t FIRST_NODE    = 10'd256;
  localparam slot_t NODE_LIMIT    = 10'd511;
  localparam node_t OVERFLOW_LEAF = 9'h0FF;

  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_BITS  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_COUNT = 1'b1;

endpackage

/* rtl/core/phd_ram.sv */
// generic single write port ram with registered read and write-first forwarding
module phd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // same-cycle write to the read address is forwarded
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/preorder_huffman_tree_decoder.sv */
// top level: pre-order serialised huffman tree builder and bit-serial decoder
//
// Usage:
//   in channel  (in_valid/in_ready, in_bit): one compressed bit per transaction,
//     xor-ed with invert_bits before use.
//   out channel (out_valid/out_ready, symbol, last_symbol): one decoded byte per
//     transaction; last_symbol marks byte number symbol_count.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 writes
//     invert_bits from cfg_data[0], index 1 writes symbol_count. Always ready;
//     write only while the block is idle.
// The first bits rebuild the tree; once it is complete every bit walks one
// level and a byte comes out at each leaf, until symbol_count bytes are out.
// Throughput: one bit per cycle while no byte waits on a low out_ready. A byte
// is presented in the cycle after the bit that reaches its leaf. Child tables
// and the slot stack are 256-entry rams whose reads are issued from the next
// walk node and next stack depth, so each bit needs a single registered read.
// Reset: tree building restarts, invert_bits = 1, symbol_count = 0. The rams
// are not cleared; the build writes every entry the walk later reads.
// A stalled receiver holds the output register; in_ready drops only while a
// byte waits and out_ready is low.
module preorder_huffman_tree_decoder #(
  parameter int COUNT_BITS = phd_pkg::PHD_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_bit,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         symbol,
  output logic                               last_symbol,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [phd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [COUNT_BITS-1:0]              cfg_data
);

  import phd_pkg::*;

  localparam logic [1:0] PH_BUILD = 2'd0;
  localparam logic [1:0] PH_WALK  = 2'd1;

  logic                  invert_bits;
  logic [COUNT_BITS-1:0] symbol_count;

  logic [1:0]            phase, phase_next;
  node_t                 root_node, root_node_next;
  logic [8:0]            stack_depth, stack_depth_next;
  slot_t                 target_slot, target_slot_next;
  slot_t                 next_free_node, next_free_node_next;
  logic [7:0]            leaf_shift, leaf_shift_next;
  logic [3:0]            leaf_bits_left, leaf_bits_left_next;
  node_t                 walk_node, walk_node_next;
  logic [COUNT_BITS-1:0] emitted_count, emitted_count_next;

  logic                  accept;
  logic                  b;
  logic                  fill_en;
  node_t                 fill_val;
  logic                  push_en;
  node_t                 push_val;
  logic                  emit;
  logic [7:0]            emit_sym;
  node_t                 child;
  node_t                 left_rd, right_rd, stack_rd;
  logic                  left_we, right_we;
  taddr_t                stack_raddr;
  logic [8:0]            depth_less_one;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign b         = in_bit ^ invert_bits;

  always_comb begin
    phase_next          = phase;
    root_node_next      = root_node;
    stack_depth_next    = stack_depth;
    target_slot_next    = target_slot;
    next_free_node_next = next_free_node;
    leaf_shift_next     = leaf_shift;
    leaf_bits_left_next = leaf_bits_left;
    walk_node_next      = walk_node;
    emitted_count_next  = emitted_count;
    fill_en             = 1'b0;
    fill_val            = '0;
    push_en             = 1'b0;
    push_val            = '0;
    emit                = 1'b0;
    emit_sym            = '0;
    child               = b ? right_rd : left_rd;

    if (accept) begin
      case (phase)
        PH_BUILD: begin
          if (leaf_bits_left != 4'd0) begin
            leaf_shift_next     = {leaf_shift[6:0], b};
            leaf_bits_left_next = leaf_bits_left - 4'd1;
            if (leaf_bits_left == 4'd1) begin
              fill_en  = 1'b1;
              fill_val = {1'b0, leaf_shift[6:0], b};
            end
          end else if (b) begin
            fill_en = 1'b1;
            if (next_free_node < NODE_LIMIT) begin
              fill_val            = next_free_node[8:0];
              push_en             = 1'b1;
              push_val            = {1'b1, next_free_node[7:0]};
              stack_depth_next    = stack_depth + 9'd1;
              target_slot_next    = {2'b00, next_free_node[7:0]};
              next_free_node_next = next_free_node + 10'd1;
            end else begin
              // node budget used up: taken as a leaf
              fill_val = OVERFLOW_LEAF;
            end
          end else begin
            leaf_shift_next     = '0;
            leaf_bits_left_next = 4'd8;
          end

          if (fill_en && target_slot == ROOT_SLOT) begin
            root_node_next = fill_val;
          end

          // a filled leaf closes a subtree: pop the next pending slot, or start walking when none is left
          if (fill_en && !push_en) begin
            if (stack_depth == 9'd0) begin
              phase_next     = PH_WALK;
              walk_node_next = root_node_next;
            end else begin
              stack_depth_next = stack_depth - 9'd1;
              target_slot_next = {1'b0, stack_rd};
            end
          end
        end
        PH_WALK: begin
          if (emitted_count < symbol_count) begin
            if (!walk_node[8]) begin
              emit     = 1'b1;
              emit_sym = walk_node[7:0];
            end else if (child[8]) begin
              walk_node_next = child;
            end else begin
              emit     = 1'b1;
              emit_sym = child[7:0];
            end
            if (emit) begin
              walk_node_next     = root_node;
              emitted_count_next = emitted_count + COUNT_BITS'(1);
            end
          end
        end
        default: begin
          phase_next = PH_BUILD;
        end
      endcase
    end
  end

  assign left_we        = fill_en && (target_slot != ROOT_SLOT) && !target_slot[8];
  assign right_we       = fill_en && (target_slot != ROOT_SLOT) && target_slot[8];
  assign depth_less_one = stack_depth_next - 9'd1;
  assign stack_raddr    = depth_less_one[7:0];

  phd_ram #(.WIDTH(NODE_W), .DEPTH(TABLE_DEPTH)) u_left (
    .clk   (clk),
    .we    (left_we),
    .waddr (target_slot[7:0]),
    .wdata (fill_val),
    .raddr (walk_node_next[7:0]),
    .rdata (left_rd)
  );

  phd_ram #(.WIDTH(NODE_W), .DEPTH(TABLE_DEPTH)) u_right (
    .clk   (clk),
    .we    (right_we),
    .waddr (target_slot[7:0]),
    .wdata (fill_val),
    .raddr (walk_node_next[7:0]),
    .rdata (right_rd)
  );

  // top of stack is read ahead from the next stack depth, so stack_rd already holds the slot a pop needs
  phd_ram #(.WIDTH(NODE_W), .DEPTH(TABLE_DEPTH)) u_stack (
    .clk   (clk),
    .we    (push_en),
    .waddr (stack_depth[7:0]),
    .wdata (push_val),
    .raddr (stack_raddr),
    .rdata (stack_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_bits    <= 1'b1;
      symbol_count   <= '0;
      phase          <= PH_BUILD;
      root_node      <= '0;
      stack_depth    <= '0;
      target_slot    <= ROOT_SLOT;
      next_free_node <= FIRST_NODE;
      leaf_shift     <= '0;
      leaf_bits_left <= '0;
      walk_node      <= '0;
      emitted_count  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INVERT_BITS:  invert_bits  <= cfg_data[0];
          REG_SYMBOL_COUNT: symbol_count <= cfg_data;
          default: ;
        endcase
      end
      phase          <= phase_next;
      root_node      <= root_node_next;
      stack_depth    <= stack_depth_next;
      target_slot    <= target_slot_next;
      next_free_node <= next_free_node_next;
      leaf_shift     <= leaf_shift_next;
      leaf_bits_left <= leaf_bits_left_next;
      walk_node      <= walk_node_next;
      emitted_count  <= emitted_count_next;
      if (accept) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      symbol      <= emit_sym;
      last_symbol <= (emitted_count_next == symbol_count);
    end
  end

`ifndef ASSERT_OFF
  // walking never starts in the middle of a leaf value
  a_walk_no_leaf: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WALK) |-> (leaf_bits_left == 4'd0))
    else $error("walk phase with leaf bits pending");

  // pending slots never outnumber the internal nodes built
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, stack_depth} <= (next_free_node - FIRST_NODE)))
    else $error("slot stack deeper than node count");

  // a bit taken while building produces no byte
  a_build_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_BUILD) |=> !out_valid)
    else $error("byte emitted during tree build");

  // a last byte leaves the count sitting at symbol_count
  a_last_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_symbol) |-> (emitted_count == symbol_count))
    else $error("last byte flagged with count mismatch");

  // node numbering stays inside the internal range
  a_node_range: assert property (@(posedge clk) disable iff (rst)
    (next_free_node >= FIRST_NODE) && (next_free_node <= NODE_LIMIT))
    else $error("next free node out of range");
`endif

endmodule

/* tb/sv/phd_tb_pkg.sv */
// bit-level mirror of the huffman tree decoder and its queue of due symbols
package phd_tb_pkg;
  import phd_pkg::*;

  typedef enum logic {GROWING_TREE, WALKING_TREE} decode_phase_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } symbol_rec_t;

  class tree_decode_mirror;
    bit                        inv_bits;
    logic [PHD_COUNT_BITS-1:0] sym_limit;
    decode_phase_t             phase;
    node_t                     left_tab[TABLE_DEPTH];
    node_t                     right_tab[TABLE_DEPTH];
    node_t                     pending_slots[TABLE_DEPTH];
    node_t                     root;
    logic [8:0]                depth;
    slot_t                     target;
    slot_t                     next_node;
    logic [7:0]                leaf_acc;
    int unsigned               leaf_left;
    node_t                     walker;
    logic [PHD_COUNT_BITS-1:0] decoded;
    symbol_rec_t               due_symbols[$];
    int unsigned               mismatches;

    function new();
      inv_bits   = 1'b1;
      sym_limit  = '0;
      phase      = GROWING_TREE;
      root       = '0;
      depth      = '0;
      target     = ROOT_SLOT;
      next_node  = FIRST_NODE;
      leaf_acc   = '0;
      leaf_left  = 0;
      walker     = '0;
      decoded    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [PHD_COUNT_BITS-1:0] data);
      if (idx == REG_INVERT_BITS) begin
        inv_bits = data[0];
      end else if (idx == REG_SYMBOL_COUNT) begin
        sym_limit = data;
      end
    endfunction

    function int pending();
      return due_symbols.size();
    endfunction

    // store a node number into whichever slot is being filled
    function void attach(node_t v);
      if (target == ROOT_SLOT) begin
        root = v;
      end else if (target[8]) begin
        right_tab[target[7:0]] = v;
      end else begin
        left_tab[target[7:0]] = v;
      end
    endfunction

    function void subtree_closed();
      if (depth == 0) begin
        phase  = WALKING_TREE;
        walker = root;
      end else begin
        depth  = depth - 1'b1;
        target = {1'b0, pending_slots[depth[7:0]]};
      end
    endfunction

    function void take_bit(logic raw);
      logic        v;
      node_t       child;
      node_t       node;
      logic [7:0]  off;
      logic [7:0]  sym;
      symbol_rec_t rec;
      v = raw ^ inv_bits;
      if (phase == GROWING_TREE) begin
        if (leaf_left != 0) begin
          leaf_acc  = {leaf_acc[6:0], v};
          leaf_left = leaf_left - 1;
          if (leaf_left == 0) begin
            attach({1'b0, leaf_acc});
            subtree_closed();
          end
        end else if (v) begin
          if (next_node < NODE_LIMIT) begin
            node      = next_node[8:0];
            off       = next_node[7:0];
            next_node = next_node + 1'b1;
            attach(node);
            pending_slots[depth[7:0]] = {1'b1, off};
            depth     = depth + 1'b1;
            target    = {2'b00, off};
          end else begin
            // node budget spent: the bit stands for leaf 0xff
            attach(OVERFLOW_LEAF);
            subtree_closed();
          end
        end else begin
          leaf_acc  = '0;
          leaf_left = 8;
        end
        return;
      end
      if (decoded >= sym_limit) return;
      if ({1'b0, walker} < FIRST_NODE) begin
        sym = walker[7:0];
      end else begin
        child = v ? right_tab[walker[7:0]] : left_tab[walker[7:0]];
        if ({1'b0, child} >= FIRST_NODE) begin
          walker = child;
          return;
        end
        sym = child[7:0];
      end
      walker    = root;
      decoded   = decoded + 1'b1;
      rec.value = sym;
      rec.last  = (decoded == sym_limit);
      due_symbols.insert(due_symbols.size(), rec);
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void match_symbol(logic [7:0] value, logic last);
      symbol_rec_t exp_rec;
      if (due_symbols.size() == 0) begin
        note_failure($sformatf("symbol %02h last %0b with nothing due", value, last));
        return;
      end
      exp_rec = due_symbols.pop_front();
      if (exp_rec.value !== value || exp_rec.last !== last) begin
        note_failure($sformatf("expected symbol %02h last %0b, got symbol %02h last %0b",
                               exp_rec.value, exp_rec.last, value, last));
      end
    endfunction
  endclass

endpackage

/* tb/sv/tb_top.sv */
// top-level testbench for the pre-order huffman tree decoder
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import phd_pkg::*;
  import phd_tb_pkg::*;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_bit    = 1'b0;
  logic                      out_ready = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index = REG_INVERT_BITS;
  logic [PHD_COUNT_BITS-1:0] cfg_data  = '0;
  logic                      in_ready;
  logic                      out_valid;
  logic                      cfg_ready;
  logic [7:0]                symbol;
  logic                      last_symbol;

  int unsigned in_gap_pct    = 31;
  int unsigned out_stall_pct = 53;

  tree_decode_mirror mirror = new();

  preorder_huffman_tree_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_bit      (in_bit),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .symbol      (symbol),
    .last_symbol (last_symbol),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) mirror.match_symbol(symbol, last_symbol);
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // valid stays high after a transaction; the next call either keeps it or drops it
  task automatic push_bit(input logic b);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bit   <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.take_bit(b);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [PHD_COUNT_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic walk_bits(input int n);
    repeat (n) push_bit($urandom_range(1));
  endtask

  // random pre-order tree using all 255 internal nodes, so that later 1 bits
  // in the build hit the exhausted node budget
  task automatic grow_tree();
    int         open_slots;
    int         made;
    int         leaf_no;
    bit         overflow_seen;
    logic [7:0] val;
    logic [7:0] corner_vals[4];
    corner_vals   = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    open_slots    = 1;
    made          = 0;
    leaf_no       = 0;
    overflow_seen = 1'b0;
    while (open_slots > 0) begin
      if (made < 255 && (open_slots == 1 || $urandom_range(99) < 90)) begin
        push_bit(1'b1 ^ mirror.inv_bits);
        made++;
        open_slots++;
      end else begin
        if (made == 255 && (!overflow_seen || $urandom_range(99) < 90)) begin
          push_bit(1'b1 ^ mirror.inv_bits);
          overflow_seen = 1'b1;
        end else begin
          val = (leaf_no < 4) ? corner_vals[leaf_no] : 8'($urandom_range(255));
          push_bit(1'b0 ^ mirror.inv_bits);
          for (int i = 7; i >= 0; i--) push_bit(val[i] ^ mirror.inv_bits);
        end
        leaf_no++;
        open_slots--;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // build under the reset setting, then walk with a zero count: nothing comes out
    grow_tree();
    walk_bits(12);
    drain();

    write_reg(REG_INVERT_BITS, '0);
    write_reg(REG_SYMBOL_COUNT, '1);
    walk_bits(200);
    drain();

    in_gap_pct    = 53;
    out_stall_pct = 31;
    write_reg(REG_INVERT_BITS, PHD_COUNT_BITS'(1));
    write_reg(REG_SYMBOL_COUNT, PHD_COUNT_BITS'(mirror.decoded + 25));
    walk_bits(200);
    drain();

    // count lowered below what has already been decoded
    write_reg(REG_SYMBOL_COUNT, mirror.decoded >> 1);
    walk_bits(20);
    drain();
    write_reg(REG_SYMBOL_COUNT, '0);
    walk_bits(20);
    drain();

    in_gap_pct    = 0;
    out_stall_pct = 0;
    write_reg(REG_INVERT_BITS, '0);
    write_reg(REG_SYMBOL_COUNT, PHD_COUNT_BITS'(mirror.decoded + 40));
    walk_bits(250);
    drain();

    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
